[sv/array_list_engine_macros.svh]
// Assertion helpers used by the list engine datapath.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define ALST_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define ALST_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/alst_pkg.sv]
`timescale 1ns / 1ps
package alst_pkg;

  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd3;

  // Controller to datapath: one strobe per step of an operation.
  typedef struct packed {
    logic capture;
    logic eval;
    logic ins_shift;
    logic ins_put;
    logic del_first;
    logic del_shift;
    logic get_rd;
    logic loc_cmp;
    logic load_out;
  } alst_cmd_t;

  // Datapath to controller: decisions for the next step.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            append;
    logic            ins_last;
    logic            del_tail;
    logic            del_last;
    logic            loc_hit;
    logic            loc_end;
    logic            empty;
    logic            out_free;
  } alst_stat_t;

endpackage

[sv/alst_datapath.sv]
`timescale 1ns / 1ps
`include "array_list_engine_macros.svh"
module alst_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [alst_pkg::OP_W-1:0]       op,
  input  logic [alst_pkg::POS_W-1:0]      position,
  input  logic signed [alst_pkg::DATA_W-1:0] value_in,
  input  alst_pkg::alst_cmd_t             cmd,
  output alst_pkg::alst_stat_t            stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            ok,
  output logic signed [alst_pkg::DATA_W-1:0] value_out,
  output logic [alst_pkg::POS_W-1:0]      found_position,
  output logic [alst_pkg::POS_W-1:0]      count,
  output logic                            is_empty
);
  import alst_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  logic [CNT_W-1:0]  cnt;
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  j;
  logic              p_ok;
  logic [DATA_W-1:0] p_val;
  logic [POS_W-1:0]  p_found;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              cnt_inc;
  logic              cnt_dec;
  logic              j_load;
  logic [IDX_W-1:0]  j_next;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  j_ext;
  logic [IDX_W-1:0]  pos_idx;
  logic              ins_bad;
  logic              rd_bad;

  // Decisions
  always_comb begin
    pos_ext = CMP_W'(pos_r);
    cnt_ext = CMP_W'(cnt);
    j_ext   = CMP_W'(j);
    pos_idx = IDX_W'(pos_r - POS_W'(1));
    ins_bad = (pos_r == '0) || (pos_ext > cnt_ext + CMP_W'(1)) ||
              (cnt_ext >= CMP_W'(CAPACITY));
    rd_bad  = (pos_r == '0) || (pos_ext > cnt_ext);

    stat.op = op_r;
    unique case (op_r) inside
      OP_INSERT:         stat.bad = ins_bad;
      OP_DELETE, OP_GET: stat.bad = rd_bad;
      default:           stat.bad = 1'b0;
    endcase
    stat.append   = (pos_ext == cnt_ext + CMP_W'(1));
    stat.ins_last = (j_ext == pos_ext);
    stat.del_tail = (pos_ext == cnt_ext);
    stat.del_last = (j_ext + CMP_W'(2) >= cnt_ext);
    stat.loc_hit  = (rd_data == val_r);
    stat.loc_end  = (j_ext + CMP_W'(1) == cnt_ext);
    stat.empty    = (cnt == '0);
    stat.out_free = !out_valid || out_ready;
  end

  // Step actions: store port controls, index and count moves
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j;
    wr_en   = 1'b0;
    wr_addr = j;
    wr_data = rd_data;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    j_load  = 1'b0;
    j_next  = j;

    if (cmd.eval && !stat.bad) begin
      unique case (op_r) inside
        OP_INSERT: begin
          if (stat.append) begin
            wr_en   = 1'b1;
            wr_addr = pos_idx;
            wr_data = val_r;
            cnt_inc = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(cnt - CNT_W'(1));
            j_load  = 1'b1;
            j_next  = IDX_W'(cnt);
          end
        end
        OP_DELETE, OP_GET: begin
          rd_en   = 1'b1;
          rd_addr = pos_idx;
          j_load  = 1'b1;
          j_next  = pos_idx;
        end
        default: begin
          rd_en   = !stat.empty;
          rd_addr = '0;
          j_load  = 1'b1;
          j_next  = '0;
        end
      endcase
    end

    if (cmd.ins_shift) begin
      wr_en = 1'b1;
      if (!stat.ins_last) begin
        rd_en   = 1'b1;
        rd_addr = j - IDX_W'(2);
        j_load  = 1'b1;
        j_next  = j - IDX_W'(1);
      end
    end

    if (cmd.ins_put) begin
      wr_en   = 1'b1;
      wr_addr = pos_idx;
      wr_data = val_r;
      cnt_inc = 1'b1;
    end

    if (cmd.del_first) begin
      if (stat.del_tail) begin
        cnt_dec = 1'b1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = j + IDX_W'(1);
      end
    end

    if (cmd.del_shift) begin
      wr_en = 1'b1;
      if (stat.del_last) begin
        cnt_dec = 1'b1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = j + IDX_W'(2);
        j_load  = 1'b1;
        j_next  = j + IDX_W'(1);
      end
    end

    if (cmd.loc_cmp && !stat.loc_hit && !stat.loc_end) begin
      rd_en   = 1'b1;
      rd_addr = j + IDX_W'(1);
      j_load  = 1'b1;
      j_next  = j + IDX_W'(1);
    end
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Latched request, index and pending result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op;
      pos_r <= position;
      val_r <= value_in;
    end
    if (j_load) begin
      j <= j_next;
    end
    if (cmd.eval) begin
      p_ok    <= !stat.bad;
      p_val   <= '0;
      p_found <= '0;
    end
    if (cmd.del_first || cmd.get_rd) begin
      p_val <= rd_data;
    end
    if (cmd.loc_cmp && stat.loc_hit) begin
      p_found <= POS_W'(j_ext + CMP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok             <= p_ok;
      value_out      <= p_val;
      found_position <= p_found;
      count          <= POS_W'(cnt);
      is_empty       <= (cnt == '0);
    end
  end

  `ALST_ASSERT_IMPL(a_cnt_cap, clk, rst, 1'b1, cnt_ext <= CMP_W'(CAPACITY), "count over capacity")
  `ALST_ASSERT_IMPL(a_port_clash, clk, rst, wr_en && rd_en, wr_addr != rd_addr, "store read and write hit one entry")
  `ALST_ASSERT_NEXT(a_load, clk, rst, cmd.load_out, out_valid, "loaded word not presented")
  `ALST_ASSERT_IMPL(a_fail_zero, clk, rst, out_valid && !ok, value_out == '0 && found_position == '0, "failed word carries data")

endmodule

[sv/alst_ctrl.sv]
`timescale 1ns / 1ps
module alst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alst_pkg::alst_stat_t stat,
  output alst_pkg::alst_cmd_t  cmd
);
  import alst_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_EVAL      = 9'b000000010,
    S_INS       = 9'b000000100,
    S_INS_PUT   = 9'b000001000,
    S_DEL_FIRST = 9'b000010000,
    S_DEL       = 9'b000100000,
    S_GET       = 9'b001000000,
    S_LOC       = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.eval      = (state == S_EVAL);
    cmd.ins_shift = (state == S_INS);
    cmd.ins_put   = (state == S_INS_PUT);
    cmd.del_first = (state == S_DEL_FIRST);
    cmd.del_shift = (state == S_DEL);
    cmd.get_rd    = (state == S_GET);
    cmd.loc_cmp   = (state == S_LOC);
    cmd.load_out  = (state == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.bad) begin
          state_next = S_DONE;
        end else begin
          unique case (stat.op)
            OP_INSERT: state_next = stat.append ? S_DONE : S_INS;
            OP_DELETE: state_next = S_DEL_FIRST;
            OP_GET:    state_next = S_GET;
            default:   state_next = stat.empty ? S_DONE : S_LOC;
          endcase
        end
      end
      S_INS: begin
        if (stat.ins_last) state_next = S_INS_PUT;
      end
      S_INS_PUT:   state_next = S_DONE;
      S_DEL_FIRST: state_next = stat.del_tail ? S_DONE : S_DEL;
      S_DEL: begin
        if (stat.del_last) state_next = S_DONE;
      end
      S_GET: state_next = S_DONE;
      S_LOC: begin
        if (stat.loc_hit || stat.loc_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/array_list_engine.sv]
`timescale 1ns / 1ps
// From the accepting edge a word is evaluated; failed words, appends and locate
//   on an empty list then go straight to done, get reads its entry, insert shifts
//   entries up and puts the value, delete reads its entry and shifts any later
//   entries down, locate compares entries from the head, up to count of them.
// Throughput: one word at a time; the next word can be taken in the cycle after a result is loaded.
// Reset (rst, synchronous): clear the count, controller and output valid; keep the store.
module array_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [alst_pkg::OP_W-1:0]          op,
  input  logic [alst_pkg::POS_W-1:0]         position,
  input  logic signed [alst_pkg::DATA_W-1:0] value_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [alst_pkg::DATA_W-1:0] value_out,
  output logic [alst_pkg::POS_W-1:0]         found_position,
  output logic [alst_pkg::POS_W-1:0]         count,
  output logic                               is_empty
);
  import alst_pkg::*;

  // Step strobes down, decisions up: the controller sequences each word's
  // walk through the store, the datapath owns the store, count and output word.
  alst_cmd_t  cmd;
  alst_stat_t stat;

  alst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Insert walks down from the tail moving one entry a cycle, delete walks up
  // from the removed slot, locate compares one entry a cycle from the head.
  alst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .position       (position),
    .value_in       (value_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .ok             (ok),
    .value_out      (value_out),
    .found_position (found_position),
    .count          (count),
    .is_empty       (is_empty)
  );

endmodule
